>>> hw/rtl/twg_pkg.sv
package twg_pkg;

  // Serial divider geometry: a 32-bit divisor and a 17-bit quotient, one bit a step.
  localparam int unsigned DivW     = 32;
  localparam int unsigned QuotW    = 17;
  localparam int unsigned DivSteps = QuotW;
  localparam int unsigned CntW     = $clog2(DivSteps);

  // Configuration register indexes
  localparam logic [1:0] RegAmplitude = 2'd0;
  localparam logic [1:0] RegPeriod    = 2'd1;
  localparam logic [1:0] RegDuty      = 2'd2;

  localparam logic [15:0] DutyHalf = 16'h8000;

  typedef struct packed {
    logic             start;
    logic [DivW-1:0]  divisor;
    logic [DivW-1:0]  dividend_hi;  // must be below the divisor
    logic [QuotW-1:0] dividend_lo;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [QuotW-1:0] quot;
    logic [DivW-1:0]  rem;
  } div_rsp_t;

endpackage

>>> hw/rtl/twg_div.sv
module twg_div (
  input  logic               clk,
  input  logic               rst_n,
  input  twg_pkg::div_req_t  req,
  output twg_pkg::div_rsp_t  rsp
);

  logic [twg_pkg::DivW-1:0]  rem_r, rem_nxt;
  logic [twg_pkg::QuotW-1:0] lo_r, lo_nxt;
  logic [twg_pkg::DivW-1:0]  dvs_r;
  logic [twg_pkg::CntW-1:0]  cnt_r;
  logic                      busy_r;
  logic                      done_r;

  logic [twg_pkg::DivW:0] shifted;
  logic                   ge;

  // One restoring step: bring in the next dividend bit, subtract if it fits.
  always_comb begin
    shifted = {rem_r, lo_r[twg_pkg::QuotW-1]};
    ge      = shifted >= {1'b0, dvs_r};
    rem_nxt = ge ? twg_pkg::DivW'(shifted - {1'b0, dvs_r})
                 : shifted[twg_pkg::DivW-1:0];
    lo_nxt  = {lo_r[twg_pkg::QuotW-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      // Pulse done for one cycle after the last step.
      done_r <= busy_r && !req.start && (cnt_r == '0);
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= twg_pkg::CntW'(twg_pkg::DivSteps - 1);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= req.dividend_hi;
      lo_r  <= req.dividend_lo;
      dvs_r <= req.divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      lo_r  <= lo_nxt;
    end
  end

  assign rsp.done = done_r;
  assign rsp.quot = lo_r;
  assign rsp.rem  = rem_r;

endmodule

>>> hw/rtl/triangle_wave_generator.sv
// Adds one point of an asymmetric triangle wave to each incoming Q8.8 sample and
// returns the saturated Q8.8 sum. The wave rises from -1 to +1 over the duty share
// of the period (duty is Q0.16, zero means one half) and falls back over the rest;
// it is scaled by the signed Q8.8 amplitude. A phase counter advances one tick per
// transfer and wraps at the period; a zero period passes the sample through and
// leaves the phase alone. Write configuration only while the block is idle.
// Timing: one transfer at a time. A sample goes through these steps, from the accept
// through the output load: accept, multiply for the peak position, operand setup,
// the bit-serial divider (17 quotient bits), amplitude multiply, round and saturate,
// output load. When a lowered period leaves the phase at or above the period, the
// divider first reduces the phase modulo the period. A zero period goes straight
// from the accept to the output load. in_tready is high only in the idle state; a
// finished result waits in the output register without holding up the next accept.
module triangle_wave_generator (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,    // [15:0] base_sample

  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,   // [15:0] sample_out

  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);

  typedef enum logic [2:0] {
    S_IDLE, S_MOD, S_SETUP, S_START, S_DIV, S_MUL, S_RND, S_OUT
  } state_t;

  state_t state_r;

  // Configuration
  logic signed [15:0] amplitude_r;
  logic [15:0]        period_r;
  logic [15:0]        duty_r;

  // Per-sample working registers
  logic [15:0]        phase_r;
  logic signed [15:0] base_r;
  logic [15:0]        t_r;
  logic [31:0]        peak_r;
  logic signed [17:0] w_r;
  logic signed [33:0] prod_r;
  logic [15:0]        res_r;
  logic               out_tvalid_r;
  logic [15:0]        out_tdata_r;

  twg_pkg::div_req_t div_req;
  twg_pkg::div_rsp_t div_rsp;

  logic               in_xfer;
  logic [15:0]        duty_eff;
  logic               rising;
  logic [31:0]        den;
  logic [15:0]        num;
  logic signed [33:0] acc;
  logic signed [33:0] acc_rnd;
  logic signed [18:0] rnd;
  logic [15:0]        sat;
  logic [16:0]        t_inc;

  assign in_tready  = (state_r == S_IDLE);
  assign in_xfer    = in_tvalid && in_tready;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  assign duty_eff = (duty_r == '0) ? twg_pkg::DutyHalf : duty_r;

  // Rising while t*65536 < duty*P; the falling span is P*65536 - peak.
  always_comb begin
    rising = {t_r, 16'b0} < peak_r;
    den    = rising ? peak_r : ({period_r, 16'b0} - peak_r);
    num    = rising ? t_r : (period_r - t_r);
  end

  // Divider operands: reduce the phase, or form round(num * 2^32 / den).
  // The dividend num*2^32 + den/2 has no carry between its parts.
  always_comb begin
    div_req = '0;
    if (state_r == S_IDLE) begin
      div_req.start       = in_xfer && (period_r != '0) && (phase_r >= period_r);
      div_req.divisor     = {16'b0, period_r};
      div_req.dividend_hi = '0;
      div_req.dividend_lo = {1'b0, phase_r};
    end else if (state_r == S_START) begin
      div_req.start       = 1'b1;
      div_req.divisor     = den;
      div_req.dividend_hi = {1'b0, num, 1'b0, den[31:18]};
      div_req.dividend_lo = den[17:1];
    end
  end

  twg_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // Round to nearest, ties up: floor((acc + 2^14) / 2^15), then saturate.
  always_comb begin
    acc     = prod_r + $signed({{3{base_r[15]}}, base_r, 15'b0});
    acc_rnd = acc + 34'sd16384;
    rnd     = acc_rnd[33:15];
    if (rnd > 19'sd32767) begin
      sat = 16'h7fff;
    end else if (rnd < -19'sd32768) begin
      sat = 16'h8000;
    end else begin
      sat = rnd[15:0];
    end
    t_inc = {1'b0, t_r} + 17'd1;
  end

  // Configuration writes; indexes beyond the list are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      amplitude_r <= '0;
      period_r    <= '0;
      duty_r      <= twg_pkg::DutyHalf;
    end else if (cfg_we) begin
      case (cfg_index)
        twg_pkg::RegAmplitude: amplitude_r <= $signed(cfg_wdata);
        twg_pkg::RegPeriod:    period_r    <= cfg_wdata;
        twg_pkg::RegDuty:      duty_r      <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      phase_r      <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      // Drop valid after a transfer unless S_OUT reloads the register now.
      if (out_tvalid_r && out_tready && (state_r != S_OUT)) begin
        out_tvalid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_xfer) begin
            base_r <= $signed(in_tdata);
            if (period_r == '0) begin
              res_r   <= in_tdata;
              state_r <= S_OUT;
            end else if (phase_r >= period_r) begin
              state_r <= S_MOD;
            end else begin
              t_r     <= phase_r;
              state_r <= S_SETUP;
            end
          end
        end
        S_MOD: begin
          if (div_rsp.done) begin
            t_r     <= div_rsp.rem[15:0];
            state_r <= S_SETUP;
          end
        end
        S_SETUP: begin
          peak_r  <= duty_eff * period_r;
          state_r <= S_START;
        end
        S_START: begin
          state_r <= S_DIV;
        end
        S_DIV: begin
          if (div_rsp.done) begin
            w_r     <= $signed({1'b0, div_rsp.quot}) - 18'sd32768;
            state_r <= S_MUL;
          end
        end
        S_MUL: begin
          prod_r  <= 34'(w_r) * 34'(amplitude_r);
          state_r <= S_RND;
        end
        S_RND: begin
          res_r   <= sat;
          phase_r <= (t_inc == {1'b0, period_r}) ? '0 : t_inc[15:0];
          state_r <= S_OUT;
        end
        S_OUT: begin
          // Hold until the output register is free, then load it.
          if (!out_tvalid_r || out_tready) begin
            out_tvalid_r <= 1'b1;
            out_tdata_r  <= res_r;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule
